[design/hwfr_pkg.sv]
// Shared types, codes and helpers for the hex word frame receiver.
// No dependencies.
package hwfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned NibW  = 4;

  localparam logic [ByteW-1:0] StartCharReset = 8'h21;
  localparam logic [ByteW-1:0] EndCharReset   = 8'h0A;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RX_ERROR = 3'd1,
    ST_BAD_END  = 3'd2,
    ST_BAD_HEX  = 3'd3,
    ST_BAD_SUM  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    POS_IDLE  = 3'd0,
    POS_DIG1  = 3'd1,
    POS_DIG2  = 3'd2,
    POS_DIG3  = 3'd3,
    POS_DIG4  = 3'd4,
    POS_CHECK = 3'd5,
    POS_TERM  = 3'd6
  } pos_t;

  typedef enum logic {
    REG_START_CHAR = 1'b0,
    REG_END_CHAR   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] word;
    status_t          status;
  } result_t;

  typedef struct packed {
    logic            ok;
    logic [NibW-1:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [ByteW-1:0] b);
    hex_digit_t d;
    d.ok    = 1'b1;
    d.value = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d.value = NibW'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d.value = NibW'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d.value = NibW'(b - 8'h37);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  function automatic logic [NibW-1:0] nibble_sum(input logic [WordW-1:0] w);
    return w[3:0] + w[7:4] + w[11:8] + w[15:12];
  endfunction

endpackage

[design/hwfr_frame.sv]
// Frame state machine: tracks position in the frame, collects the word and
// check digit, and forms one result per frame. Depends on hwfr_pkg.
module hwfr_frame (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [hwfr_pkg::ByteW-1:0]   rx_byte,
  input  logic                         rx_bad,
  input  logic [hwfr_pkg::ByteW-1:0]   start_char,
  input  logic [hwfr_pkg::ByteW-1:0]   end_char,
  output hwfr_pkg::result_t            res
);
  import hwfr_pkg::*;

  pos_t             position, position_next;
  logic [WordW-1:0] word_accum, word_accum_next;
  logic [NibW-1:0]  check_digit, check_digit_next;
  logic             hex_error, hex_error_next;
  hex_digit_t       dig;

  assign dig = hex_decode(rx_byte);

  // next state
  always_comb begin
    position_next    = position;
    word_accum_next  = word_accum;
    check_digit_next = check_digit;
    hex_error_next   = hex_error;
    if (step) begin
      unique case (position)
        POS_DIG1, POS_DIG2, POS_DIG3, POS_DIG4, POS_CHECK: begin
          if (rx_bad) begin
            position_next = POS_IDLE;
          end else begin
            hex_error_next = hex_error | ~dig.ok;
            if (position == POS_CHECK) begin
              check_digit_next = dig.value;
              position_next    = POS_TERM;
            end else begin
              word_accum_next = {word_accum[WordW-NibW-1:0], dig.value};
              position_next   = pos_t'(position + 3'd1);
            end
          end
        end
        POS_TERM: position_next = POS_IDLE;
        default: begin
          if (!rx_bad && rx_byte == start_char) begin
            position_next    = POS_DIG1;
            word_accum_next  = '0;
            check_digit_next = '0;
            hex_error_next   = 1'b0;
          end else begin
            position_next = POS_IDLE;
          end
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    res.valid  = 1'b0;
    res.word   = '0;
    res.status = ST_OK;
    if (step) begin
      unique case (position)
        POS_DIG1, POS_DIG2, POS_DIG3, POS_DIG4, POS_CHECK: begin
          if (rx_bad) begin
            res.valid  = 1'b1;
            res.status = ST_RX_ERROR;
          end
        end
        POS_TERM: begin
          res.valid = 1'b1;
          priority if (rx_bad || rx_byte != end_char) begin
            res.status = ST_BAD_END;
          end else if (hex_error) begin
            res.status = ST_BAD_HEX;
          end else if (check_digit != nibble_sum(word_accum)) begin
            res.status = ST_BAD_SUM;
          end else begin
            res.status = ST_OK;
            res.word   = word_accum;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= POS_IDLE;
      word_accum  <= '0;
      check_digit <= '0;
      hex_error   <= 1'b0;
    end else begin
      position    <= position_next;
      word_accum  <= word_accum_next;
      check_digit <= check_digit_next;
      hex_error   <= hex_error_next;
    end
  end

endmodule

[design/hex_word_frame_receiver.sv]
// Top level of the hex word frame receiver: config registers, frame state
// machine and a two-entry output stage. Depends on hwfr_pkg, hwfr_frame.
//
// Usage:
//   Input stream s_axis carries one received byte per item in tdata, with
//   the receive-error flag in tuser. Output stream m_axis carries one item
//   per frame: the decoded word and a status code.
//   A frame is start char, four hex digits (msn first), one hex check digit
//   (sum of the nibbles mod 16) and the end char. A receive error inside the
//   digits ends the frame at once with status 1.
//   Throughput: one input item per cycle while s_axis_tready is high. The
//   result of a frame is registered into the output register or skid entry.
//   Output register plus one skid entry: input keeps flowing while a result
//   waits; s_axis_tready drops only when both entries hold results.
//   Config: cfg_we writes cfg_wdata to register cfg_addr (0 start char,
//   1 end char); write only while idle.
//   Reset (rst, synchronous): frame state to idle, start char 0x21, end
//   char 0x0A, output stage empty.
module hex_word_frame_receiver (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] rx_byte
  input  logic                       s_axis_tuser,   // [0] rx_bad
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [23:0]                m_axis_tdata,   // [15:0] word, [18:16] status, pad
  input  logic                       cfg_we,
  input  hwfr_pkg::cfg_idx_t         cfg_addr,
  input  logic [hwfr_pkg::ByteW-1:0] cfg_wdata
);
  import hwfr_pkg::*;

  logic [ByteW-1:0] start_char;
  logic [ByteW-1:0] end_char;
  logic             accept;
  result_t          res;
  logic             out_valid;
  logic [WordW-1:0] out_word;
  status_t          out_status;
  logic             skid_valid;
  logic [WordW-1:0] skid_word;
  status_t          skid_status;

  assign s_axis_tready = ~skid_valid;
  assign accept        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= StartCharReset;
      end_char   <= EndCharReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_START_CHAR: start_char <= cfg_wdata;
        REG_END_CHAR:   end_char   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  hwfr_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .rx_byte    (s_axis_tdata),
    .rx_bad     (s_axis_tuser),
    .start_char (start_char),
    .end_char   (end_char),
    .res        (res)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid  <= skid_valid | res.valid;
      skid_valid <= 1'b0;
    end else if (res.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_word   <= skid_word;
        out_status <= skid_status;
      end else begin
        out_word   <= res.word;
        out_status <= res.status;
      end
    end else if (res.valid) begin
      skid_word   <= res.word;
      skid_status <= res.status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_status, out_word};

endmodule
